### rtl/core/udu_pkg.sv
// Shared types, codes and the one-bit restoring divide step for the divide unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps
package udu_pkg;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int unsigned STEPS = 32;

    // One division in flight: partial remainder, dividend/quotient shift word,
    // divisor and the status found by the front end.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] den;
    } op_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic op_t div_step(op_t a);
        op_t         res;
        logic [32:0] t;
        logic        qbit;
        res  = a;
        t    = {a.hi, a.lo[31]};
        qbit = (t >= {1'b0, a.den});
        if (qbit) begin
            t = t - {1'b0, a.den};
        end
        res.hi = t[31:0];
        res.lo = {a.lo[30:0], qbit};
        return res;
    endfunction

endpackage

### rtl/core/unsigned_divide_unit.sv
// Top level of the unsigned divide unit (x86 DIV for byte, word, doubleword sizes).
// Depends on udu_pkg, udu_front, udu_queue and udu_back.
`timescale 1ns / 1ps
// The unit takes one divide transaction per clock while the output is not stalled and
// returns one result per transaction, in order. An accepted transaction is written
// into the two-entry input queue, passes from there to the first pipeline stage
// and then ripples through the remaining 31 stages, each of which retires one
// quotient bit.
// Throughput is one transaction per cycle while m_tready stays high. All operand
// sizes are widened to a 64 by 32 division; the front end flags a zero divisor or
// a quotient that would not fit the operand size before the division starts, and
// such results come out with quotient and remainder forced to zero. Operation
// code 3 behaves as doubleword.
module unsigned_divide_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [63:0] dividend, [95:64] divisor
    input  logic [1:0]   s_tuser,   // [1:0] operation (operand size)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [31:0] quotient, [63:32] remainder
    output logic [1:0]   m_tuser    // [1:0] status
);
    import udu_pkg::*;

    op_t        front_op;
    op_t        queue_op;
    logic       queue_valid;
    logic       back_ready;
    logic [1:0] queue_count;
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic [1:0]  status;

    // Classify the incoming transaction.
    udu_front u_front (
        .operation (s_tuser),
        .dividend  (s_tdata[63:0]),
        .divisor   (s_tdata[95:64]),
        .op        (front_op)
    );

    // Hold classified transactions while the pipeline stalls.
    udu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_op),
        .rd_valid (queue_valid),
        .rd_ready (back_ready),
        .rd_data  (queue_op),
        .count    (queue_count)
    );

    // Run the division.
    udu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (queue_valid),
        .in_ready      (back_ready),
        .in_op         (queue_op),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_quotient  (quotient),
        .out_remainder (remainder),
        .out_status    (status)
    );

    assign m_tdata = {remainder, quotient};
    assign m_tuser = status;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 64'd0))
        else $error("failed division carries nonzero results");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_DIV_ZERO ||
                      m_tuser == ST_OVERFLOW))
        else $error("undefined status code");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_count != 2'd3)
        else $error("queue count out of range");

    a_queue_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (queue_count == 2'd2) |-> !s_tready)
        else $error("full queue still accepts");

endmodule

### rtl/core/udu_front.sv
// Front end of the divide unit: masks operands to the operand size and classifies.
// Depends on udu_pkg.
`timescale 1ns / 1ps
module udu_front (
    input  logic [1:0]    operation,
    input  logic [63:0]   dividend,
    input  logic [31:0]   divisor,
    output udu_pkg::op_t  op
);
    import udu_pkg::*;

    logic [63:0] num;
    logic [31:0] den;
    logic [31:0] upper;

    // Widen every size to 64 by 32; the quotient fits the operand size iff upper < den.
    always_comb begin
        unique case (operation)
            SIZE_BYTE: begin
                num   = {48'd0, dividend[15:0]};
                den   = {24'd0, divisor[7:0]};
                upper = {24'd0, dividend[15:8]};
            end
            SIZE_WORD: begin
                num   = {32'd0, dividend[31:0]};
                den   = {16'd0, divisor[15:0]};
                upper = {16'd0, dividend[31:16]};
            end
            default: begin
                num   = dividend;
                den   = divisor;
                upper = dividend[63:32];
            end
        endcase
    end

    always_comb begin
        op.den = den;
        op.lo  = num[31:0];
        op.hi  = num[63:32];
        if (den == 32'd0) begin
            op.status = ST_DIV_ZERO;
        end else if (upper >= den) begin
            op.status = ST_OVERFLOW;
        end else begin
            op.status = ST_OK;
        end
        // Clear the partial remainder on errors; this keeps it below a nonzero divisor.
        if (op.status != ST_OK) begin
            op.hi = 32'd0;
        end
    end

endmodule

### rtl/core/udu_queue.sv
// Two-entry queue that decouples the front end from the divide pipeline.
// Depends on udu_pkg.
`timescale 1ns / 1ps
module udu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  udu_pkg::op_t  wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output udu_pkg::op_t  rd_data,
    output logic [1:0]    count
);
    import udu_pkg::*;

    op_t        mem [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign count    = count_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/udu_back.sv
// Back end of the divide unit: 32-stage restoring divide pipeline, one bit per stage.
// Depends on udu_pkg.
`timescale 1ns / 1ps
module udu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  udu_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_quotient,
    output logic [31:0]   out_remainder,
    output logic [1:0]    out_status
);
    import udu_pkg::*;

    op_t  stage_reg [0:STEPS-1];
    logic [STEPS-1:0] valid_reg;
    logic [STEPS-1:0] valid_next;
    logic advance;

    // Advance the whole pipe unless the last stage holds an untaken transaction.
    assign advance  = !valid_reg[STEPS-1] || out_ready;
    assign in_ready = advance;

    always_comb begin
        valid_next = {valid_reg[STEPS-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stage_reg[0] <= div_step(in_op);
        end
    end

    for (genvar k = 1; k < STEPS; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (advance) begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    assign out_valid     = valid_reg[STEPS-1];
    assign out_status    = stage_reg[STEPS-1].status;
    // Drop the results of a failed division.
    assign out_quotient  = (out_status == ST_OK) ? stage_reg[STEPS-1].lo : 32'd0;
    assign out_remainder = (out_status == ST_OK) ? stage_reg[STEPS-1].hi : 32'd0;

endmodule
